@@ rtl/ecg_pkg.sv @@
// Shared types, constants and helper functions for the easing curve generator.
package ecg_pkg;

  // Position and value formats
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int VAL_W     = FRAC_BITS + 2;
  localparam int QB        = 30;              // internal fraction bits
  localparam int P_W       = QB + 1;          // internal position width
  localparam int CODE_W    = 4;

  localparam logic [POS_W-1:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [33:0]      Q_ONE   = 34'd1 << QB;
  localparam logic [P_W-1:0]   Q_ONE_P = {1'b1, {QB{1'b0}}};
  localparam logic [31:0]      HALF_PI_Q = 32'd1686629713;
  localparam logic [31:0]      LN2_Q     = 32'd744261118;
  localparam logic [63:0]      MUL_RND   = 64'd1 << (QB - 1);
  // 9/4 turn offset plus one, elastic phase numerator
  localparam logic [33:0]      EL_OFS    = 34'd2415919105;
  localparam logic [7:0]       EL_DIV3   = 8'd3;

  // Divider and root unit sizes
  localparam int DIV_W    = 40;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = DIV_W / DIV_STEP;
  localparam int SQ_W     = 62;
  localparam int SQ_STEPS = 31;

  // Opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_RUN_FWD = 3'd1;
  localparam logic [2:0] OP_RUN_BWD = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_SET_POS = 3'd4;

  // Curve codes
  localparam logic [CODE_W-1:0] CRV_INOUT_SINE  = 4'd0;
  localparam logic [CODE_W-1:0] CRV_LINEAR      = 4'd1;
  localparam logic [CODE_W-1:0] CRV_INOUT_CUBIC = 4'd2;
  localparam logic [CODE_W-1:0] CRV_INOUT_QUAD  = 4'd3;
  localparam logic [CODE_W-1:0] CRV_INOUT_CIRC  = 4'd4;
  localparam logic [CODE_W-1:0] CRV_IN_QUINT    = 4'd5;
  localparam logic [CODE_W-1:0] CRV_OUT_SINE    = 4'd6;
  localparam logic [CODE_W-1:0] CRV_OUT_ELASTIC = 4'd7;
  localparam logic [CODE_W-1:0] CRV_OUT_QUINT   = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_FWD_CURVE = 2'd0;
  localparam logic [1:0] CFG_BWD_CURVE = 2'd1;
  localparam logic [1:0] CFG_STEP      = 2'd2;

  localparam logic [CODE_W-1:0] CURVE_RST = 4'd1;
  localparam logic [POS_W-1:0]  STEP_RST  = 17'd1092;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [POS_W-1:0] new_position;
  } ecg_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] eased_value;
    logic [POS_W-1:0]        position;
    logic                    done_res;
    logic                    running;
  } ecg_out_t;

  typedef struct packed {
    logic [P_W-1:0]    p;
    logic [CODE_W-1:0] code;
  } ecg_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [7:0]       divisor;
  } ecg_div_req_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } ecg_sqrt_req_t;

  typedef enum logic [4:0] {
    CS_IDLE, CS_DISPATCH,
    CS_SIN_TH, CS_SIN_M1, CS_SIN_M2, CS_SIN_D, CS_SIN_W, CS_SIN_END,
    CS_SQ_M, CS_SQ_W,
    CS_POW_M, CS_POW_W,
    CS_CIRC_S, CS_CIRC_W,
    CS_EL_DW, CS_EL_TH, CS_EL_Y, CS_EL_Y2,
    CS_EXP_M, CS_EXP_D, CS_EXP_W, CS_EXP_END,
    CS_EL_MAG, CS_EL_FIN,
    CS_DONE
  } ecg_state_t;

  // Divisors of the sine series, 2k(2k+1)
  function automatic logic [7:0] sin_divisor(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd1:    d = 8'd6;
      3'd2:    d = 8'd20;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd72;
      3'd5:    d = 8'd110;
      3'd6:    d = 8'd156;
      3'd7:    d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // Q30 to Q2.16, rounding half away from zero
  function automatic logic [VAL_W-1:0] to_out(input logic signed [35:0] v);
    logic [35:0] mag;
    logic [35:0] r;
    mag = v[35] ? 36'(-v) : 36'(v);
    r   = (mag + (36'd1 << (QB - FRAC_BITS - 1))) >> (QB - FRAC_BITS);
    if (v[35]) begin
      r = 36'(-r);
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/ecg_div.sv @@
// Iterative divider by a small divisor, eight quotient bits per cycle.
module ecg_div import ecg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ecg_div_req_t     req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic             busy_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic [DIV_W-1:0] shf_r;
  logic [7:0]       rem_r;
  logic [7:0]       dsr_r;

  logic [8:0]       rem_v;
  logic [DIV_W-1:0] shf_v;

  // one digit of eight restoring steps
  always_comb begin
    rem_v = {1'b0, rem_r};
    shf_v = shf_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem_v = {rem_v[7:0], shf_v[DIV_W-1]};
      shf_v = {shf_v[DIV_W-2:0], 1'b0};
      if (rem_v >= {1'b0, dsr_r}) begin
        rem_v    = rem_v - {1'b0, dsr_r};
        shf_v[0] = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working word: dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      shf_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      shf_r <= shf_v;
      rem_r <= rem_v[7:0];
    end
  end

  assign done = done_r;
  assign quot = shf_r;

endmodule

@@ rtl/ecg_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
module ecg_sqrt import ecg_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ecg_sqrt_req_t  req,
  output logic           done,
  output logic [P_W-1:0] root
);

  logic            busy_r;
  logic            done_r;
  logic [4:0]      cnt_r;
  logic [SQ_W-1:0] x_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] sum_w;

  assign sum_w = r_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // compare, subtract and shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.radicand;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (2 * (SQ_STEPS - 1));
    end else if (busy_r) begin
      if (x_r >= sum_w) begin
        x_r <= x_r - sum_w;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[P_W-1:0];

endmodule

@@ rtl/ecg_core.sv @@
// Curve sequencer: shared multiplier, divider and root unit under one state machine.
module ecg_core import ecg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ecg_req_t         req,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] res_value
);

  ecg_state_t state_r, state_nxt;

  logic [P_W-1:0]     p_r;
  logic [CODE_W-1:0]  code_r;
  logic [31:0]        th_r, th_nxt;
  logic [33:0]        term_r, term_nxt;
  logic signed [35:0] sum_r, sum_nxt;
  logic [3:0]         k_r, k_nxt;
  logic [31:0]        b_r, b_nxt;
  logic [31:0]        rr_r, rr_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [1:0]         q2_r, q2_nxt;
  logic [3:0]         n_r, n_nxt;
  logic [31:0]        s_r, s_nxt;
  logic signed [35:0] val_r, val_nxt;
  logic [33:0]        qm_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_w;
  ecg_div_req_t       div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  ecg_sqrt_req_t      sq_req;
  logic               sq_done;
  logic [P_W-1:0]     sq_root;

  logic               low_w;
  logic [31:0]        u_w, w_w, x_w;
  logic [33:0]        e_w, tn_w;
  logic [31:0]        sclamp_w;
  logic [32:0]        amp_w;
  logic [33:0]        amp_sh_w;
  logic [33:0]        msat_w, mdiff_w;
  logic [P_W-1:0]     rc_w;
  logic signed [35:0] sum_upd_w;
  logic signed [35:0] q_one_s;

  ecg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  ecg_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  // shared multiplier with Q30 rounding, registered
  assign prod_w = 64'(mul_a) * 64'(mul_b) + MUL_RND;

  always_ff @(posedge clk) begin
    qm_r <= prod_w[63:QB];
  end

  // operand helpers
  assign q_one_s  = $signed({2'b00, Q_ONE});
  assign low_w    = (p_r[P_W-1:P_W-2] == 2'b00);
  assign u_w      = {p_r, 1'b0};
  assign w_w      = {Q_ONE_P - p_r, 1'b0};
  assign x_w      = low_w ? u_w : w_w;
  assign e_w      = {p_r, 3'b000} + {2'b00, p_r, 1'b0};
  assign tn_w     = e_w + EL_OFS;
  assign sum_upd_w = k_r[0] ? (sum_r - $signed({2'b00, div_quot[33:0]}))
                            : (sum_r + $signed({2'b00, div_quot[33:0]}));

  // sine result clamped to [0, 1]
  always_comb begin
    if (sum_r[35]) begin
      sclamp_w = '0;
    end else if (sum_r > q_one_s) begin
      sclamp_w = Q_ONE[31:0];
    end else begin
      sclamp_w = sum_r[31:0];
    end
  end

  // exponential amplitude, rounded shift by the whole part of 10p
  assign amp_w    = sum_r[35] ? '0 : sum_r[32:0];
  assign amp_sh_w = ({1'b0, amp_w} + ((34'd1 << n_r) >> 1)) >> n_r;

  // circular helpers
  assign msat_w  = (qm_r > Q_ONE) ? Q_ONE : qm_r;
  assign mdiff_w = Q_ONE - msat_w;
  assign rc_w    = (sq_root > Q_ONE_P) ? Q_ONE_P : sq_root;

  // state register and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == CS_IDLE) begin
      p_r    <= req.p;
      code_r <= req.code;
    end
    th_r   <= th_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    k_r    <= k_nxt;
    b_r    <= b_nxt;
    rr_r   <= rr_nxt;
    cnt_r  <= cnt_nxt;
    q2_r   <= q2_nxt;
    n_r    <= n_nxt;
    s_r    <= s_nxt;
    val_r  <= val_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    th_nxt    = th_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    rr_nxt    = rr_r;
    cnt_nxt   = cnt_r;
    q2_nxt    = q2_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    val_nxt   = val_r;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    sq_req    = '0;
    res_valid = 1'b0;

    case (state_r)
      CS_IDLE: begin
        if (start) begin
          state_nxt = CS_DISPATCH;
        end
      end

      CS_DISPATCH: begin
        case (code_r)
          CRV_INOUT_SINE, CRV_OUT_SINE: begin
            mul_a     = HALF_PI_Q;
            mul_b     = {1'b0, p_r};
            state_nxt = CS_SIN_TH;
          end
          CRV_LINEAR: begin
            val_nxt   = $signed({5'd0, p_r});
            state_nxt = CS_DONE;
          end
          CRV_INOUT_CUBIC, CRV_INOUT_QUAD: begin
            b_nxt     = x_w;
            rr_nxt    = x_w;
            cnt_nxt   = (code_r == CRV_INOUT_CUBIC) ? 3'd2 : 3'd1;
            state_nxt = CS_POW_M;
          end
          CRV_IN_QUINT: begin
            b_nxt     = {1'b0, p_r};
            rr_nxt    = {1'b0, p_r};
            cnt_nxt   = 3'd4;
            state_nxt = CS_POW_M;
          end
          CRV_OUT_QUINT: begin
            b_nxt     = {1'b0, Q_ONE_P - p_r};
            rr_nxt    = {1'b0, Q_ONE_P - p_r};
            cnt_nxt   = 3'd4;
            state_nxt = CS_POW_M;
          end
          CRV_INOUT_CIRC: begin
            mul_a     = x_w;
            mul_b     = x_w;
            state_nxt = CS_CIRC_S;
          end
          CRV_OUT_ELASTIC: begin
            if (p_r == '0) begin
              val_nxt   = '0;
              state_nxt = CS_DONE;
            end else if (p_r >= Q_ONE_P) begin
              val_nxt   = q_one_s;
              state_nxt = CS_DONE;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = {6'd0, tn_w};
              div_req.divisor  = EL_DIV3;
              state_nxt        = CS_EL_DW;
            end
          end
          default: begin
            val_nxt   = '0;
            state_nxt = CS_DONE;
          end
        endcase
      end

      // sine series: load angle
      CS_SIN_TH: begin
        th_nxt    = qm_r[31:0];
        term_nxt  = {2'b00, qm_r[31:0]};
        sum_nxt   = $signed({4'd0, qm_r[31:0]});
        k_nxt     = 4'd1;
        state_nxt = CS_SIN_M1;
      end
      CS_SIN_M1: begin
        mul_a     = term_r[31:0];
        mul_b     = th_r;
        state_nxt = CS_SIN_M2;
      end
      CS_SIN_M2: begin
        mul_a     = qm_r[31:0];
        mul_b     = th_r;
        state_nxt = CS_SIN_D;
      end
      CS_SIN_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = {6'd0, qm_r};
        div_req.divisor  = sin_divisor(k_r[2:0]);
        state_nxt        = CS_SIN_W;
      end
      CS_SIN_W: begin
        if (div_done) begin
          term_nxt = div_quot[33:0];
          sum_nxt  = sum_upd_w;
          if (k_r == 4'd7) begin
            state_nxt = CS_SIN_END;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = CS_SIN_M1;
          end
        end
      end
      CS_SIN_END: begin
        s_nxt = sclamp_w;
        if (code_r == CRV_INOUT_SINE) begin
          state_nxt = CS_SQ_M;
        end else if (code_r == CRV_OUT_SINE) begin
          val_nxt   = $signed({4'd0, sclamp_w});
          state_nxt = CS_DONE;
        end else begin
          state_nxt = CS_EL_Y;
        end
      end

      // in-out sine squares the sine
      CS_SQ_M: begin
        mul_a     = s_r;
        mul_b     = s_r;
        state_nxt = CS_SQ_W;
      end
      CS_SQ_W: begin
        val_nxt   = $signed({2'b00, qm_r});
        state_nxt = CS_DONE;
      end

      // integer powers
      CS_POW_M: begin
        mul_a     = rr_r;
        mul_b     = b_r;
        state_nxt = CS_POW_W;
      end
      CS_POW_W: begin
        rr_nxt = qm_r[31:0];
        if (cnt_r == 3'd1) begin
          if (code_r == CRV_IN_QUINT) begin
            val_nxt = $signed({2'b00, qm_r});
          end else if (code_r == CRV_OUT_QUINT) begin
            val_nxt = q_one_s - $signed({2'b00, qm_r});
          end else if (low_w) begin
            val_nxt = $signed({3'b000, qm_r[33:1]});
          end else begin
            val_nxt = q_one_s - $signed({3'b000, qm_r[33:1]});
          end
          state_nxt = CS_DONE;
        end else begin
          cnt_nxt   = cnt_r - 3'd1;
          state_nxt = CS_POW_M;
        end
      end

      // circular: root of one minus square
      CS_CIRC_S: begin
        sq_req.start    = 1'b1;
        sq_req.radicand = {1'b0, mdiff_w[P_W-1:0], {QB{1'b0}}};
        state_nxt       = CS_CIRC_W;
      end
      CS_CIRC_W: begin
        if (sq_done) begin
          if (low_w) begin
            val_nxt = $signed({5'd0, Q_ONE_P - rc_w}) >>> 1;
          end else begin
            val_nxt = $signed({4'd0, {1'b0, sq_root} + {1'b0, Q_ONE_P}}) >>> 1;
          end
          state_nxt = CS_DONE;
        end
      end

      // elastic: phase, then sine, then decay
      CS_EL_DW: begin
        mul_a = {2'b00, div_quot[27:0], 2'b00};
        mul_b = HALF_PI_Q;
        if (div_done) begin
          q2_nxt    = div_quot[29:28];
          state_nxt = CS_EL_TH;
        end
      end
      CS_EL_TH: begin
        th_nxt    = q2_r[0] ? (HALF_PI_Q - qm_r[31:0]) : qm_r[31:0];
        term_nxt  = {2'b00, th_nxt};
        sum_nxt   = $signed({4'd0, th_nxt});
        k_nxt     = 4'd1;
        state_nxt = CS_SIN_M1;
      end
      CS_EL_Y: begin
        mul_a     = {2'b00, e_w[QB-1:0]};
        mul_b     = LN2_Q;
        n_nxt     = e_w[33:30];
        state_nxt = CS_EL_Y2;
      end
      CS_EL_Y2: begin
        th_nxt    = qm_r[31:0];
        term_nxt  = Q_ONE;
        sum_nxt   = q_one_s;
        k_nxt     = 4'd1;
        state_nxt = CS_EXP_M;
      end

      // exponential series
      CS_EXP_M: begin
        mul_a     = term_r[31:0];
        mul_b     = th_r;
        state_nxt = CS_EXP_D;
      end
      CS_EXP_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = {6'd0, qm_r};
        div_req.divisor  = {4'd0, k_r};
        state_nxt        = CS_EXP_W;
      end
      CS_EXP_W: begin
        if (div_done) begin
          term_nxt = div_quot[33:0];
          sum_nxt  = sum_upd_w;
          if (k_r == 4'd13) begin
            state_nxt = CS_EXP_END;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = CS_EXP_M;
          end
        end
      end
      CS_EXP_END: begin
        rr_nxt    = amp_sh_w[31:0];
        state_nxt = CS_EL_MAG;
      end
      CS_EL_MAG: begin
        mul_a     = rr_r;
        mul_b     = s_r;
        state_nxt = CS_EL_FIN;
      end
      CS_EL_FIN: begin
        if (q2_r[1]) begin
          val_nxt = q_one_s - $signed({2'b00, qm_r});
        end else begin
          val_nxt = q_one_s + $signed({2'b00, qm_r});
        end
        state_nxt = CS_DONE;
      end

      CS_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = CS_IDLE;
        end
      end

      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  assign idle      = (state_r == CS_IDLE);
  assign res_value = to_out(val_r);

endmodule

@@ rtl/easing_curve_generator.sv @@
// Easing curve generator: position, direction and run state with curve evaluation.
// The time from input word to result word depends on the curve and is set by the series on the
// shared multiplier and by the divisions.
// One word at a time: input ready returns once the result has left the core.
// Synchronous active-low reset: position 0, forward, stopped, curves linear, step 1092.
module easing_curve_generator import ecg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ecg_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ecg_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [POS_W-1:0] cfg_wdata
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              dir_r, dir_nxt;
  logic              started_r, started_nxt;
  logic [CODE_W-1:0] fwd_curve_r;
  logic [CODE_W-1:0] bwd_curve_r;
  logic [POS_W-1:0]  step_r;
  logic              out_valid_r;
  ecg_out_t          out_data_r;

  logic              in_acc;
  logic              core_idle;
  logic              res_valid;
  logic              res_ready;
  logic [VAL_W-1:0]  res_value;
  ecg_req_t          core_req;
  logic [POS_W:0]    fwd_sum;
  logic              done_w;

  assign in_acc  = in_valid && in_ready;
  assign fwd_sum = {1'b0, pos_r} + {1'b0, step_r};

  // command decode
  always_comb begin
    pos_nxt     = pos_r;
    dir_nxt     = dir_r;
    started_nxt = started_r;
    case (in_data.opcode)
      OP_TICK: begin
        if (started_r) begin
          if (dir_r) begin
            pos_nxt = (fwd_sum > {1'b0, POS_ONE}) ? POS_ONE : fwd_sum[POS_W-1:0];
          end else begin
            pos_nxt = (step_r >= pos_r) ? '0 : pos_r - step_r;
          end
        end
      end
      OP_RUN_FWD: begin
        dir_nxt     = 1'b1;
        started_nxt = 1'b1;
      end
      OP_RUN_BWD: begin
        dir_nxt     = 1'b0;
        started_nxt = 1'b1;
      end
      OP_STOP: begin
        started_nxt = 1'b0;
        pos_nxt     = '0;
      end
      OP_SET_POS: begin
        pos_nxt = (in_data.new_position > POS_ONE) ? POS_ONE : in_data.new_position;
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  assign core_req.p    = {pos_nxt, {(QB - FRAC_BITS){1'b0}}};
  assign core_req.code = dir_nxt ? fwd_curve_r : bwd_curve_r;

  // tween state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      dir_r     <= 1'b1;
      started_r <= 1'b0;
    end else if (in_acc) begin
      pos_r     <= pos_nxt;
      dir_r     <= dir_nxt;
      started_r <= started_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_curve_r <= CURVE_RST;
      bwd_curve_r <= CURVE_RST;
      step_r      <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FWD_CURVE: fwd_curve_r <= cfg_wdata[CODE_W-1:0];
        CFG_BWD_CURVE: bwd_curve_r <= cfg_wdata[CODE_W-1:0];
        CFG_STEP:      step_r      <= cfg_wdata;
        default:       step_r      <= step_r;
      endcase
    end
  end

  ecg_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .req      (core_req),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_value(res_value)
  );

  assign in_ready  = core_idle;
  assign res_ready = !out_valid_r || out_ready;
  assign done_w    = dir_r ? (pos_r >= POS_ONE) : (pos_r == '0);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r.eased_value <= res_value;
      out_data_r.position    <= pos_r;
      out_data_r.done_res    <= done_w;
      out_data_r.running     <= started_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/ecg_checker.sv @@
// Port-level checks for the easing curve generator, bound to the top level.
module ecg_checker import ecg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ecg_out_t         out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // block is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after accept");

  // position stays within one
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position <= POS_ONE)
    else $error("position above one");

  // done only at an end point
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      (out_data.position == POS_ONE) || (out_data.position == '0))
    else $error("done away from an end");

endmodule

bind easing_curve_generator ecg_checker u_ecg_checker (.*);

@@ bench/easing_curve_checker.sv @@
// Checker for the easing curve generator: predicts each result word and compares it.
module easing_curve_checker import ecg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  ecg_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  ecg_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [POS_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  localparam logic [63:0] QO   = 64'd1 << QB;
  localparam logic [63:0] QH   = 64'd1 << (QB - 1);
  localparam logic [63:0] HPI  = 64'd1686629713;
  localparam logic [63:0] LN2  = 64'd744261118;

  // Predictor state
  logic [POS_W-1:0]  tw_pos;
  logic              tw_fwd;
  logic              tw_run;
  logic [CODE_W-1:0] fwd_code;
  logic [CODE_W-1:0] bwd_code;
  logic [POS_W-1:0]  step_inc;

  ecg_out_t expected_words[$];

  function automatic logic [63:0] qm(input logic [63:0] a, input logic [63:0] b);
    return (a * b + QH) >> QB;
  endfunction

  function automatic logic [63:0] q_sin(input logic [63:0] th);
    longint sum;
    logic [63:0] term;
    sum  = longint'(th);
    term = th;
    for (int k = 1; k <= 7; k++) begin
      term = qm(qm(term, th), th) / 64'((2 * k) * (2 * k + 1));
      if (k & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(QO)) sum = longint'(QO);
    return 64'(sum);
  endfunction

  function automatic logic [63:0] q_expneg(input logic [63:0] y);
    longint sum;
    logic [63:0] term;
    sum  = longint'(QO);
    term = QO;
    for (int k = 1; k <= 13; k++) begin
      term = qm(term, y) / 64'(k);
      if (k & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] q_pow(input logic [63:0] a, input int n);
    logic [63:0] r;
    r = a;
    for (int i = 1; i < n; i++) r = qm(r, a);
    return r;
  endfunction

  function automatic longint elastic_val(input logic [63:0] p);
    logic [63:0] t, f, q, r, th, s, e, amp, n, mag;
    if (p == 0) return 0;
    if (p >= QO) return longint'(QO);
    // phase in turns, one extra turn keeps it positive
    t   = (64'd10 * p + 64'd9 * (QO >> 2) + 64'd1) / 64'd3;
    f   = t & (QO - 1);
    q   = f >> (QB - 2);
    r   = f & ((QO >> 2) - 1);
    th  = qm(r << 2, HPI);
    s   = q[0] ? q_sin(HPI - th) : q_sin(th);
    e   = 64'd10 * p;
    n   = e >> QB;
    amp = q_expneg(qm(e & (QO - 1), LN2));
    if (n > 0) amp = (amp + (64'd1 << (n - 1))) >> n;
    mag = qm(amp, s);
    return (q >= 2) ? longint'(QO) - longint'(mag) : longint'(QO) + longint'(mag);
  endfunction

  function automatic longint curve_val(input logic [CODE_W-1:0] code, input logic [63:0] p);
    logic        lo;
    logic [63:0] u, w, s;
    lo = p < (QO >> 1);
    u  = 2 * p;
    w  = 2 * (QO - p);
    case (code)
      CRV_INOUT_SINE: begin
        s = q_sin(qm(HPI, p));
        return longint'(qm(s, s));
      end
      CRV_LINEAR:      return longint'(p);
      CRV_INOUT_CUBIC: return lo ? longint'(q_pow(u, 3) >> 1)
                                 : longint'(QO - (q_pow(w, 3) >> 1));
      CRV_INOUT_QUAD:  return lo ? longint'(q_pow(u, 2) >> 1)
                                 : longint'(QO - (q_pow(w, 2) >> 1));
      CRV_INOUT_CIRC: begin
        if (lo) begin
          s = int_root((QO - qm(u, u)) << QB);
          if (s > QO) s = QO;
          return longint'((QO - s) >> 1);
        end
        s = qm(w, w);
        if (s > QO) s = QO;
        s = int_root((QO - s) << QB);
        return longint'((s + QO) >> 1);
      end
      CRV_IN_QUINT:    return longint'(q_pow(p, 5));
      CRV_OUT_SINE:    return longint'(q_sin(qm(HPI, p)));
      CRV_OUT_ELASTIC: return elastic_val(p);
      CRV_OUT_QUINT:   return longint'(QO - q_pow(QO - p, 5));
      default:         return 0;
    endcase
  endfunction

  // Q30 to Q2.16, half away from zero
  function automatic logic [VAL_W-1:0] round_out(input longint v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (QB - FRAC_BITS - 1))) >> (QB - FRAC_BITS);
    if (v < 0) m = 64'(-m);
    return m[VAL_W-1:0];
  endfunction

  // Apply one command word and form the result it gives
  function automatic ecg_out_t apply_command(input ecg_in_t w);
    ecg_out_t r;
    logic [POS_W:0]    sum;
    logic [CODE_W-1:0] code;
    case (w.opcode)
      OP_TICK: begin
        if (tw_run) begin
          if (tw_fwd) begin
            sum = {1'b0, tw_pos} + {1'b0, step_inc};
            tw_pos = (sum > {1'b0, POS_ONE}) ? POS_ONE : sum[POS_W-1:0];
          end else begin
            tw_pos = (step_inc >= tw_pos) ? '0 : tw_pos - step_inc;
          end
        end
      end
      OP_RUN_FWD: begin
        tw_fwd = 1'b1;
        tw_run = 1'b1;
      end
      OP_RUN_BWD: begin
        tw_fwd = 1'b0;
        tw_run = 1'b1;
      end
      OP_STOP: begin
        tw_run = 1'b0;
        tw_pos = '0;
      end
      OP_SET_POS: tw_pos = (w.new_position > POS_ONE) ? POS_ONE : w.new_position;
      default: ;
    endcase
    code          = tw_fwd ? fwd_code : bwd_code;
    r.eased_value = round_out(curve_val(code, 64'(tw_pos) << (QB - FRAC_BITS)));
    r.position    = tw_pos;
    r.done_res    = tw_fwd ? (tw_pos >= POS_ONE) : (tw_pos == 0);
    r.running     = tw_run;
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    ecg_out_t want;
    if (!rst_n) begin
      tw_pos      = '0;
      tw_fwd      = 1'b1;
      tw_run      = 1'b0;
      fwd_code   <= CURVE_RST;
      bwd_code   <= CURVE_RST;
      step_inc   <= STEP_RST;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FWD_CURVE: fwd_code <= cfg_wdata[CODE_W-1:0];
          CFG_BWD_CURVE: bwd_code <= cfg_wdata[CODE_W-1:0];
          CFG_STEP:      step_inc <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_words.push_back(apply_command(in_data));
      // Compare the result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display({"mismatch: exp val %0d pos %0d done %b run %b, ",
                        "got val %0d pos %0d done %b run %b"},
                       want.eased_value, want.position, want.done_res, want.running,
                       out_data.eased_value, out_data.position, out_data.done_res,
                       out_data.running);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/easing_curve_generator_tb.sv @@
// Testbench top: clock, reset, command stimulus, configuration phases and verdict.
module easing_curve_generator_tb;
  import ecg_pkg::*;

  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_CYC   = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  ecg_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  ecg_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [POS_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  logic             calm = 1'b0;      // no idling on either side
  logic             hold_out = 1'b0;  // long receiver hold-off request

  always #5 clk = ~clk;

  easing_curve_generator dut (.*);
  easing_curve_checker chk (.*);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    int hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_out && hold_left == 0) begin
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= (hold_left == 0);
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // Offer one command word and wait for its acceptance; valid drops only when idling
  task automatic send_word(input logic [2:0] op, input logic [POS_W-1:0] np);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, new_position: np};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_curves(input logic [CODE_W-1:0] f, input logic [CODE_W-1:0] b,
                            input logic [POS_W-1:0] st);
    wait_idle();
    write_reg(CFG_FWD_CURVE, f);
    write_reg(CFG_BWD_CURVE, b);
    write_reg(CFG_STEP, st);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(5))
      0:       return '0;
      1:       return POS_ONE;
      2:       return POS_ONE + 17'($urandom_range(65535));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // A run: start, then several commands, mostly ticks, sometimes a jump, stop, unused opcode or new run
  task automatic tween_run();
    int n;
    send_word($urandom_range(1) ? OP_RUN_FWD : OP_RUN_BWD, 17'($urandom));
    n = $urandom_range(12, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:       send_word(OP_SET_POS, rand_pos());
        1:       send_word(OP_STOP, 17'($urandom));
        2:       send_word(3'($urandom_range(7, 5)), 17'($urandom));
        3:       send_word($urandom_range(1) ? OP_RUN_FWD : OP_RUN_BWD, 17'($urandom));
        default: send_word(OP_TICK, 17'($urandom));
      endcase
    end
  endtask

  initial begin
    int sent;
    logic [POS_W-1:0] st;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick while stopped, both ends, unused opcodes, all curves
    send_word(OP_TICK, 17'h1FFFF);
    send_word(OP_SET_POS, 17'h1FFFF);
    send_word(OP_SET_POS, POS_ONE);
    send_word(OP_RUN_FWD, '0);
    send_word(OP_TICK, '0);
    send_word(3'd5, 17'h1FFFF);
    send_word(3'd7, '0);
    send_word(OP_RUN_BWD, '0);
    send_word(OP_SET_POS, 17'd1);
    send_word(OP_TICK, '0);
    send_word(OP_STOP, 17'h1FFFF);
    for (int c = 0; c <= 15; c++) begin
      set_curves(CODE_W'(c), CODE_W'(15 - c), (c == 0) ? 17'd0 : POS_ONE >> (c % 8));
      send_word(OP_SET_POS, 17'($urandom_range(65536)));
      send_word(OP_RUN_FWD, '0);
      send_word(OP_RUN_BWD, '0);
    end

    // Receiver hold-off while commands keep coming
    set_curves(CRV_LINEAR, CRV_OUT_SINE, STEP_RST);
    hold_out <= 1'b1;
    @(posedge clk);
    hold_out <= 1'b0;
    for (int i = 0; i < 6; i++) send_word(OP_TICK, '0);

    // Random phases; sender pauses until drained at each phase change
    sent = 0;
    while (sent < 550) begin
      st = $urandom_range(3) == 0 ? ($urandom_range(1) ? 17'd1 : POS_ONE)
                                   : 17'($urandom_range(16384, 1));
      if ($urandom_range(9) == 0) st = 17'($urandom_range(65536));
      set_curves(4'($urandom_range(9)), 4'($urandom_range(9)), st);
      calm <= (sent > 200 && sent < 300);
      for (int j = 0; j < 5; j++) begin
        tween_run();
        sent += 8;
      end
    end
    calm <= 1'b0;
    wait_idle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
